// ===== rtl/zrb64_pkg.sv =====
// Shared types, constants and the base64 alphabet for the zero-run base64 encoder.
// No dependencies; every other file in rtl imports this package.
package zrb64_pkg;

  localparam logic [5:0]  GPL_RESET = 6'd19;
  localparam logic [31:0] RUN_CAP   = 32'hFFFF_FFFF;
  localparam logic [6:0]  PAD_CHAR  = 7'h3D;

  // Queue between the run coder and the base64 packer.
  localparam int unsigned QAW    = 2;
  localparam int unsigned QDEPTH = 1 << QAW;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } zrb64_in_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       line_end;
    logic       stream_end;
  } zrb64_out_t;

  // One coded byte; last marks the final coded byte of a stream.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } zrb64_code_t;

  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] c;
    case (idx) inside
      [6'd0:6'd25]:  c = 7'h41 + {1'b0, idx};
      [6'd26:6'd51]: c = 7'h47 + {1'b0, idx};
      [6'd52:6'd61]: c = {1'b0, idx} - 7'd4;
      6'd62:         c = 7'h2B;
      default:       c = 7'h2F;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/zrb64_front.sv =====
// Zero-run coder: accepts raw bytes and sends coded bytes into the queue one per cycle while it is not full.
// Depends on zrb64_pkg.
module zrb64_front import zrb64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  zrb64_in_t   in_data,
  output logic        q_push,
  output zrb64_code_t q_data,
  input  logic        q_full
);

  logic [31:0] run_len, run_len_next;
  logic        busy, busy_next;
  logic [2:0]  pos, pos_next;
  logic [31:0] flush_len;
  logic [7:0]  lit;
  logic        has_lit, last;

  logic        take, at_end, seq_done;
  logic [31:0] run_inc, flush_n, run_take;
  logic        has_run_n, has_lit_n;
  logic [7:0]  byte_out;

  // A sequence is up to five run bytes (positions 0 to 4) and then the literal (position 5).
  assign at_end   = has_lit ? (pos == 3'd5) : (pos == 3'd4);
  assign q_push   = busy && !q_full;
  assign seq_done = q_push && at_end;
  assign in_stall = busy && !seq_done;
  assign take     = in_valid && !in_stall;
  assign run_inc  = run_len + 32'd1;

  always_comb begin
    has_lit_n = 1'b0;
    has_run_n = 1'b0;
    flush_n   = run_inc;
    run_take  = 32'd0;
    if (in_data.data_byte != 8'd0) begin
      has_lit_n = 1'b1;
      has_run_n = (run_len != 32'd0);
      flush_n   = run_len;
    end else if (run_inc == RUN_CAP || in_data.final_byte) begin
      has_run_n = 1'b1;
    end else begin
      run_take  = run_inc;
    end
  end

  always_comb begin
    case (pos)
      3'd0:    byte_out = 8'd0;
      3'd1:    byte_out = flush_len[7:0];
      3'd2:    byte_out = flush_len[15:8];
      3'd3:    byte_out = flush_len[23:16];
      3'd4:    byte_out = flush_len[31:24];
      default: byte_out = lit;
    endcase
    q_data.value = byte_out;
    q_data.last  = last && at_end;
  end

  always_comb begin
    run_len_next = take ? run_take : run_len;
    if (take) begin
      busy_next = has_run_n || has_lit_n;
      pos_next  = has_run_n ? 3'd0 : 3'd5;
    end else begin
      busy_next = busy && !seq_done;
      pos_next  = q_push ? pos + 3'd1 : pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_len <= 32'd0;
      busy    <= 1'b0;
      pos     <= 3'd0;
    end else begin
      run_len <= run_len_next;
      busy    <= busy_next;
      pos     <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      flush_len <= flush_n;
      lit       <= in_data.data_byte;
      has_lit   <= has_lit_n;
      last      <= in_data.final_byte;
    end
  end

endmodule

// ===== rtl/zrb64_fifo.sv =====
// Short queue of coded bytes between the run coder and the base64 packer.
// Depends on zrb64_pkg.
module zrb64_fifo import zrb64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  zrb64_code_t push_data,
  output logic        full,
  input  logic        pop,
  output zrb64_code_t pop_data,
  output logic        empty
);

  zrb64_code_t       entries [QDEPTH];
  logic [QAW-1:0]    wr_ptr, rd_ptr;
  logic [QAW:0]      count;

  assign full     = (count == QDEPTH[QAW:0]);
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/zrb64_back.sv =====
// Base64 packer: gathers coded bytes into groups of three and sends four characters per group.
// Depends on zrb64_pkg.
module zrb64_back import zrb64_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [5:0]  groups_per_line,
  input  logic        q_empty,
  input  zrb64_code_t q_data,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output zrb64_out_t  out_data
);

  logic [7:0]  p0, p1;
  logic [1:0]  pcnt, pcnt_next;
  logic [5:0]  gil, gil_next;
  logic        g_valid, g_valid_next;
  logic [23:0] g_val, g_val_n;
  logic [1:0]  g_nvalid, g_nvalid_n;
  logic        g_last, g_close, g_close_n;
  logic [1:0]  g_pos, g_pos_next;
  logic        o_valid, o_valid_next;
  zrb64_out_t  o_data, o_data_n;

  logic out_free, emit, g_free, completes, load;

  assign out_free  = !o_valid || !out_stall;
  assign emit      = g_valid && out_free;
  assign g_free    = !g_valid || (emit && g_pos == 2'd3);
  assign completes = (pcnt == 2'd2) || q_data.last;
  assign q_pop     = !q_empty && (!completes || g_free);
  assign load      = q_pop && completes;

  assign out_valid = o_valid;
  assign out_data  = o_data;

  // Missing bytes of a short final group read as zero.
  always_comb begin
    case (pcnt)
      2'd1: begin
        g_val_n    = {p0, q_data.value, 8'd0};
        g_nvalid_n = 2'd2;
      end
      2'd2: begin
        g_val_n    = {p0, p1, q_data.value};
        g_nvalid_n = 2'd3;
      end
      default: begin
        g_val_n    = {q_data.value, 16'd0};
        g_nvalid_n = 2'd1;
      end
    endcase
    g_close_n = ({1'b0, gil} + 7'd1 >= {1'b0, groups_per_line}) || q_data.last;
  end

  always_comb begin
    o_data_n = '0;
    case (g_pos)
      2'd0: o_data_n.text_char = b64_char(g_val[23:18]);
      2'd1: o_data_n.text_char = b64_char(g_val[17:12]);
      2'd2: o_data_n.text_char = (g_nvalid > 2'd1) ? b64_char(g_val[11:6]) : PAD_CHAR;
      default: begin
        o_data_n.text_char  = (g_nvalid > 2'd2) ? b64_char(g_val[5:0]) : PAD_CHAR;
        o_data_n.line_end   = g_close;
        o_data_n.stream_end = g_last;
      end
    endcase
  end

  always_comb begin
    pcnt_next    = pcnt;
    gil_next     = gil;
    g_valid_next = g_valid;
    g_pos_next   = g_pos;
    if (q_pop) begin
      pcnt_next = completes ? 2'd0 : pcnt + 2'd1;
    end
    if (emit) begin
      g_pos_next = g_pos + 2'd1;
      if (g_pos == 2'd3) begin
        g_valid_next = 1'b0;
      end
    end
    if (load) begin
      gil_next     = g_close_n ? 6'd0 : gil + 6'd1;
      g_valid_next = 1'b1;
      g_pos_next   = 2'd0;
    end
    if (emit) begin
      o_valid_next = 1'b1;
    end else begin
      o_valid_next = o_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcnt    <= 2'd0;
      gil     <= 6'd0;
      g_valid <= 1'b0;
      g_pos   <= 2'd0;
      o_valid <= 1'b0;
    end else begin
      pcnt    <= pcnt_next;
      gil     <= gil_next;
      g_valid <= g_valid_next;
      g_pos   <= g_pos_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && !completes) begin
      if (pcnt == 2'd0) begin
        p0 <= q_data.value;
      end else begin
        p1 <= q_data.value;
      end
    end
    if (load) begin
      g_val    <= g_val_n;
      g_nvalid <= g_nvalid_n;
      g_last   <= q_data.last;
      g_close  <= g_close_n;
    end
    if (emit) begin
      o_data <= o_data_n;
    end
  end

endmodule

// ===== rtl/zero_run_rle_base64_encoder_top.sv =====
// Top level of the zero-run base64 encoder: line length register, run coder, queue, packer.
// Depends on zrb64_pkg, zrb64_front, zrb64_fifo and zrb64_back.

// The block zero-run codes a byte stream and sends it out as base64 text, one character
// per accepted output item. In the run coder a zero byte inside a run is taken and
// produces nothing, a nonzero byte produces one coded byte, and closing a run adds five
// more; the coder takes no new byte until it has sent every coded byte of the last one.
// The packer sends one character per cycle while the output is not stalled, so for plain
// data its single output register sets the rate at four characters per three input bytes.
// A four-entry queue separates the two, so input keeps flowing while output is stalled
// until the queue fills. groups_per_line may be written only while the block is idle.
module zero_run_rle_base64_encoder_top import zrb64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  zrb64_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output zrb64_out_t out_data,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata
);

  logic [5:0]  groups_per_line;
  logic        q_push, q_full, q_pop, q_empty;
  zrb64_code_t q_in, q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line <= GPL_RESET;
    end else if (cfg_we) begin
      groups_per_line <= cfg_wdata;
    end
  end

  zrb64_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_in),
    .q_full   (q_full)
  );

  zrb64_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  zrb64_back u_back (
    .clk             (clk),
    .rst             (rst),
    .groups_per_line (groups_per_line),
    .q_empty         (q_empty),
    .q_data          (q_out),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data)
  );

  // The last character of a stream always closes its line.
  a_end_closes_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.stream_end |-> out_data.line_end)
    else $error("stream end without line end");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !q_push)
    else $error("coded byte pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_empty |-> !q_pop)
    else $error("coded byte popped from an empty queue");

endmodule
